// ===== sv/npvl_pkg.sv =====
package npvl_pkg;

    // Field widths fixed by the item format.
    localparam int COORD_W    = 24;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 10;
    localparam int TSIZE_W    = 11;
    localparam int MIRROR_W   = 2;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Default sizes handed to the top level.
    localparam int TABLE_DEPTH_DEF  = 1024;
    localparam int MAX_VERTICES_DEF = 8;

    // Request kinds.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Mirror axis codes.
    localparam logic [MIRROR_W-1:0] MIRROR_X = 2'd1;
    localparam logic [MIRROR_W-1:0] MIRROR_Y = 2'd2;
    localparam logic [MIRROR_W-1:0] MIRROR_Z = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_AXIS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 2'd1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    // One stored table entry.
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        value_t value;
    } entry_t;

endpackage

// ===== sv/npvl_if.sv =====
// Request channel: load items and query vertices.
interface npvl_req_if;
    import npvl_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [INDEX_W-1:0] entry_index;
    coord_t             point_x;
    coord_t             point_y;
    coord_t             point_z;
    value_t             entry_value;
    logic               last_vertex;

    modport source (
        output valid, req_type, entry_index, point_x, point_y, point_z,
               entry_value, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, req_type, entry_index, point_x, point_y, point_z,
               entry_value, last_vertex,
        output ready
    );
endinterface

// Response channel: one item per closed face.
interface npvl_rsp_if;
    import npvl_pkg::*;

    logic             valid;
    logic             ready;
    value_t           face_value;
    logic [CNT_W-1:0] matched_count;

    modport source (
        output valid, face_value, matched_count,
        input  ready
    );

    modport sink (
        input  valid, face_value, matched_count,
        output ready
    );
endinterface

// Configuration write channel.
interface npvl_cfg_if;
    import npvl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== sv/npvl_table.sv =====
module npvl_table #(
    parameter int DEPTH = npvl_pkg::TABLE_DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  npvl_pkg::entry_t  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output npvl_pkg::entry_t  rd_data
);
    import npvl_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/npvl_div.sv =====
module npvl_div #(
    parameter int SUM_W = 35
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [SUM_W-1:0]      dividend,
    input  logic [npvl_pkg::CNT_W-1:0]   divisor,
    output logic                         done,
    output npvl_pkg::value_t             quotient
);
    import npvl_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIX  = 2'd2;
    localparam logic [1:0] D_DONE = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    value_t            res_reg;

    logic [SUM_W-1:0]  mag;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_diff;
    logic              fits;
    logic [CNT_W-1:0]  rem_new;

    // Magnitude of the dividend; the most negative sum maps to its own bit pattern.
    assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

    // One restoring step: shift in the next dividend bit and try the subtract.
    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, dsr_reg};
    assign fits       = trial >= {1'b0, dsr_reg};
    assign rem_new    = fits ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    state_next = D_FIX;
                end
            end
            D_FIX:
            begin
                state_next = D_DONE;
            end
            D_DONE:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == D_IDLE && start)
            begin
                step_reg <= STEP_W'(SUM_W);
            end
            else if (state_reg == D_RUN)
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            dsr_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (state_reg == D_RUN)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= rem_new;
        end
        else if (state_reg == D_FIX)
        begin
            res_reg <= neg_reg ? -quo_reg[VALUE_W-1:0] : quo_reg[VALUE_W-1:0];
        end
    end

    assign done     = (state_reg == D_DONE);
    assign quotient = res_reg;

endmodule

// ===== sv/nearest_point_value_lookup.sv =====
// Load item: written in the cycle it is accepted; ready stays high.
// Query vertex: one shared 25x25 squarer handles one axis per cycle, so each scanned
// entry passes through SQ_X, SQ_Y, SQ_Z and CMP; a vertex scans n = min(table_size,
// TABLE_DEPTH) entries before the next item can be accepted.
// Closing a face with matches runs a 1-bit-per-cycle divider; the result waits in PUSH until the output is free.
// Reset clears control state, registers and face sums; table contents stay undefined.
module nearest_point_value_lookup #(
    parameter int TABLE_DEPTH  = npvl_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_VERTICES = npvl_pkg::MAX_VERTICES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    npvl_req_if.sink   req,
    npvl_rsp_if.source rsp,
    npvl_cfg_if.sink   cfg
);
    import npvl_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int SCAN_W = ADDR_W + 1;
    localparam int LIM_W  = (SCAN_W > TSIZE_W) ? SCAN_W : TSIZE_W;
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int DIST_W = SQ_W + 2;
    localparam int SUM_W  = VALUE_W + $clog2(MAX_VERTICES);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ_X  = 4'd1;
    localparam logic [3:0] ST_SQ_Y  = 4'd2;
    localparam logic [3:0] ST_SQ_Z  = 4'd3;
    localparam logic [3:0] ST_CMP   = 4'd4;
    localparam logic [3:0] ST_ACC   = 4'd5;
    localparam logic [3:0] ST_CLOSE = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_PUSH  = 4'd8;

    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    logic [MIRROR_W-1:0]     mirror_reg;
    logic [TSIZE_W-1:0]      tsize_reg;
    coord_t                  qx_reg;
    coord_t                  qy_reg;
    coord_t                  qz_reg;
    logic                    last_reg;
    logic [SCAN_W-1:0]       idx_reg;
    logic [SCAN_W-1:0]       idx_next;
    logic [SCAN_W-1:0]       n_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [DIST_W-1:0]       acc_reg;
    logic                    found_reg;
    logic [DIST_W-1:0]       best_reg;
    value_t                  best_val_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    value_t                  pend_val_reg;
    logic                    out_valid_reg;
    value_t                  out_val_reg;
    logic [CNT_W-1:0]        out_cnt_reg;

    logic                    req_accept;
    logic                    is_query;
    logic [LIM_W-1:0]        tsize_ext;
    logic [SCAN_W-1:0]       scan_len;
    logic [SCAN_W-1:0]       idx_inc;
    logic                    scan_last;
    logic [LIM_W-1:0]        load_idx;
    logic                    wr_en;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    entry_t                  wr_entry;
    entry_t                  rd_entry;
    coord_t                  axis_a;
    coord_t                  axis_p;
    logic                    mirror_hit;
    logic signed [DIFF_W-1:0] a_ext;
    logic signed [DIFF_W-1:0] p_ext;
    logic signed [DIFF_W-1:0] a_abs;
    logic signed [DIFF_W-1:0] p_abs;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]       mag;
    logic [SQ_W-1:0]         sq_val;
    logic [DIST_W-1:0]       add_a;
    logic [DIST_W-1:0]       add_sum;
    logic                    better;
    logic                    take;
    logic                    push_ok;
    logic                    div_start;
    logic                    div_done;
    value_t                  div_quot;

    // Handshakes. Configuration is always taken.
    assign req.ready  = (state_reg == ST_IDLE);
    assign req_accept = req.valid && req.ready;
    assign is_query   = (req.req_type == REQ_QUERY);
    assign cfg.ready  = 1'b1;

    // Scan length saturates at the table depth.
    assign tsize_ext = LIM_W'(tsize_reg);
    assign scan_len  = (tsize_ext > LIM_W'(TABLE_DEPTH)) ? SCAN_W'(TABLE_DEPTH)
                                                         : tsize_ext[SCAN_W-1:0];
    assign idx_inc   = idx_reg + 1'b1;
    assign scan_last = (idx_inc == n_reg);

    // Table write on load items; out-of-range indexes are dropped.
    assign load_idx       = LIM_W'(req.entry_index);
    assign wr_en          = req_accept && (req.req_type == REQ_LOAD)
                            && (load_idx < LIM_W'(TABLE_DEPTH));
    assign wr_entry.x     = req.point_x;
    assign wr_entry.y     = req.point_y;
    assign wr_entry.z     = req.point_z;
    assign wr_entry.value = req.entry_value;

    // Read entry 0 on query accept, the next entry at each compare but the last.
    assign rd_en   = (req_accept && is_query) || (state_reg == ST_CMP && !scan_last);
    assign rd_addr = (state_reg == ST_IDLE) ? '0 : idx_inc[ADDR_W-1:0];

    npvl_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (load_idx[ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // Axis selection for the shared squarer.
    always_comb
    begin
        unique case (state_reg)
            ST_SQ_Y:
            begin
                axis_a     = rd_entry.y;
                axis_p     = qy_reg;
                mirror_hit = (mirror_reg == MIRROR_Y);
            end
            ST_SQ_Z:
            begin
                axis_a     = rd_entry.z;
                axis_p     = qz_reg;
                mirror_hit = (mirror_reg == MIRROR_Z);
            end
            default:
            begin
                axis_a     = rd_entry.x;
                axis_p     = qx_reg;
                mirror_hit = (mirror_reg == MIRROR_X);
            end
        endcase
    end

    // On the mirrored axis the nearer of a and -a lies at ||a| - |p||.
    assign a_ext  = DIFF_W'(axis_a);
    assign p_ext  = DIFF_W'(axis_p);
    assign a_abs  = axis_a[COORD_W-1] ? -a_ext : a_ext;
    assign p_abs  = axis_p[COORD_W-1] ? -p_ext : p_ext;
    assign diff   = mirror_hit ? (a_abs - p_abs) : (a_ext - p_ext);
    assign mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign sq_val = mag * mag;

    // Shared adder: starts the distance on y, adds on z and at compare.
    assign add_a   = (state_reg == ST_SQ_Y) ? '0 : acc_reg;
    assign add_sum = add_a + DIST_W'(sq_reg);
    assign better  = !found_reg || (add_sum < best_reg);

    assign take      = found_reg && (cnt_reg < CNT_W'(MAX_VERTICES));
    assign push_ok   = !out_valid_reg || rsp.ready;
    assign div_start = (state_reg == ST_CLOSE) && (cnt_reg != '0);

    npvl_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (req_accept && is_query)
                begin
                    state_next = (scan_len == '0) ? ST_ACC : ST_SQ_X;
                end
            end
            ST_SQ_X:
            begin
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                state_next = ST_SQ_Z;
            end
            ST_SQ_Z:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (scan_last)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    state_next = ST_SQ_X;
                    idx_next   = idx_inc;
                end
            end
            ST_ACC:
            begin
                state_next = last_reg ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE:
            begin
                state_next = (cnt_reg == '0) ? ST_PUSH : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (push_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and face accumulation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            mirror_reg    <= '0;
            tsize_reg     <= '0;
            found_reg     <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;

            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_MIRROR_AXIS: mirror_reg <= cfg.data[MIRROR_W-1:0];
                    REG_TABLE_SIZE:  tsize_reg  <= cfg.data[TSIZE_W-1:0];
                    default:         ;
                endcase
            end

            if (req_accept && is_query)
            begin
                found_reg <= 1'b0;
            end
            else if (state_reg == ST_CMP)
            begin
                found_reg <= 1'b1;
            end

            if (state_reg == ST_ACC && take)
            begin
                sum_reg <= sum_reg + SUM_W'(best_val_reg);
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (state_reg == ST_PUSH && push_ok)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end

            if (state_reg == ST_PUSH && push_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (req_accept && is_query)
        begin
            qx_reg   <= req.point_x;
            qy_reg   <= req.point_y;
            qz_reg   <= req.point_z;
            last_reg <= req.last_vertex;
            n_reg    <= scan_len;
        end

        if (state_reg == ST_SQ_X || state_reg == ST_SQ_Y || state_reg == ST_SQ_Z)
        begin
            sq_reg <= sq_val;
        end

        if (state_reg == ST_SQ_Y || state_reg == ST_SQ_Z)
        begin
            acc_reg <= add_sum;
        end

        // Strictly smaller distance wins, so a tie keeps the lower index.
        if (state_reg == ST_CMP && better)
        begin
            best_reg     <= add_sum;
            best_val_reg <= rd_entry.value;
        end

        if (state_reg == ST_CLOSE)
        begin
            pend_val_reg <= '0;
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            pend_val_reg <= div_quot;
        end

        if (state_reg == ST_PUSH && push_ok)
        begin
            out_val_reg <= pend_val_reg;
            out_cnt_reg <= cnt_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.face_value    = out_val_reg;
    assign rsp.matched_count = out_cnt_reg;

endmodule

// ===== sv/npvl_checker.sv =====
module npvl_checker #(
    parameter int MAX_VERTICES = npvl_pkg::MAX_VERTICES_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       req_type,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input npvl_pkg::value_t           face_value,
    input logic [npvl_pkg::CNT_W-1:0] matched_count
);
    import npvl_pkg::*;

    // A result item stays offered until taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result item dropped before it was taken");

    // A stalled result item keeps its fields.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(face_value) && $stable(matched_count))
        else $error("stalled result item changed");

    // The matched count never exceeds the vertex limit.
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> matched_count <= CNT_W'(MAX_VERTICES))
        else $error("matched count above vertex limit");

    // A face with no match reports zero.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && matched_count == '0 |-> face_value == '0)
        else $error("empty face gave a nonzero value");

    // A query vertex occupies the scan, so the next cycle takes no item.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_QUERY |=> !req_ready)
        else $error("item accepted right after a query vertex");

endmodule

bind nearest_point_value_lookup npvl_checker #(
    .MAX_VERTICES (MAX_VERTICES)
) u_npvl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_type      (req.req_type),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .face_value    (rsp.face_value),
    .matched_count (rsp.matched_count)
);

// ===== tb/npvl_face_checker.sv =====
module npvl_face_checker
    import npvl_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    npvl_req_if  req,
    npvl_rsp_if  rsp,
    npvl_cfg_if  cfg,
    output int   mismatch_count,
    output int   faces_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        value_t           face_value;
        logic [CNT_W-1:0] matched_count;
    } face_result_t;

    // Shadow copy of the point table and the block's registers.
    coord_t              pt_x     [TABLE_DEPTH];
    coord_t              pt_y     [TABLE_DEPTH];
    coord_t              pt_z     [TABLE_DEPTH];
    value_t              pt_value [TABLE_DEPTH];
    logic [MIRROR_W-1:0] mirror_sel;
    logic [TSIZE_W-1:0]  scan_size;

    // Running state of the face that is currently open.
    longint              face_sum;
    int                  face_vertices;

    // Face averages that the block still owes, oldest first.
    face_result_t        face_results_q[$];

    function automatic longint sq_dist(input longint ax, input longint ay, input longint az,
                                       input longint bx, input longint by, input longint bz);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) + (az - bz) * (az - bz);
    endfunction

    // Index of the nearest scanned entry, or -1 when the scan is empty.
    // The mirror image is measured at full precision, so no coordinate wraps.
    function automatic int nearest_entry(input coord_t qx, input coord_t qy, input coord_t qz);
        int     n;
        int     best_idx;
        longint best;
        longint d;
        longint dm;
        longint ex;
        longint ey;
        longint ez;
        n = (int'(scan_size) > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_size);
        best_idx = -1;
        best = 0;
        for (int i = 0; i < n; i++) begin
            ex = pt_x[i];
            ey = pt_y[i];
            ez = pt_z[i];
            d = sq_dist(ex, ey, ez, qx, qy, qz);
            case (mirror_sel)
                MIRROR_X: dm = sq_dist(-ex, ey, ez, qx, qy, qz);
                MIRROR_Y: dm = sq_dist(ex, -ey, ez, qx, qy, qz);
                MIRROR_Z: dm = sq_dist(ex, ey, -ez, qx, qy, qz);
                default:  dm = d;
            endcase
            if (dm < d)
                d = dm;
            // Strict compare keeps the lower index on a tie.
            if (best_idx < 0 || d < best) begin
                best = d;
                best_idx = i;
            end
        end
        return best_idx;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n) begin
        int           idx;
        face_result_t owed;
        face_result_t face_res;
        if (!rst_n) begin
            mirror_sel = '0;
            scan_size = '0;
            face_sum = 0;
            face_vertices = 0;
            face_results_q.delete();
            faces_pending = 0;
        end else begin
            // Register writes.
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_MIRROR_AXIS: mirror_sel = cfg.data[MIRROR_W-1:0];
                    REG_TABLE_SIZE:  scan_size = cfg.data[TSIZE_W-1:0];
                    default: ;
                endcase
            end

            // Results are compared before this edge's request is predicted,
            // since a result can never stem from the item accepted with it.
            if (rsp.valid && rsp.ready) begin
                if (face_results_q.size() == 0) begin
                    note_mismatch($sformatf("result with no face closed: face_value %0d, matched_count %0d",
                                            rsp.face_value, rsp.matched_count));
                end else begin
                    owed = face_results_q.pop_front();
                    if (rsp.face_value !== owed.face_value)
                        note_mismatch($sformatf("face_value expected %0d, got %0d",
                                                owed.face_value, rsp.face_value));
                    if (rsp.matched_count !== owed.matched_count)
                        note_mismatch($sformatf("matched_count expected %0d, got %0d",
                                                owed.matched_count, rsp.matched_count));
                end
            end

            // Loads update the table; a query adds its nearest value to the open face up to the vertex limit.
            if (req.valid && req.ready) begin
                if (req.req_type == REQ_LOAD) begin
                    idx = int'(req.entry_index);
                    if (idx < TABLE_DEPTH) begin
                        pt_x[idx] = req.point_x;
                        pt_y[idx] = req.point_y;
                        pt_z[idx] = req.point_z;
                        pt_value[idx] = req.entry_value;
                    end
                end else begin
                    idx = nearest_entry(req.point_x, req.point_y, req.point_z);
                    if (idx >= 0 && face_vertices < MAX_VERTICES) begin
                        face_sum += longint'(pt_value[idx]);
                        face_vertices++;
                    end
                    if (req.last_vertex) begin
                        face_res.face_value = (face_vertices == 0) ? '0 :
                                              value_t'(face_sum / longint'(face_vertices));
                        face_res.matched_count = CNT_W'(face_vertices);
                        face_results_q.push_back(face_res);
                        face_sum = 0;
                        face_vertices = 0;
                    end
                end
            end

            faces_pending = face_results_q.size();
        end
    end

endmodule

// ===== tb/tb_nearest_point_value_lookup.sv =====
module tb_nearest_point_value_lookup;
    timeunit 1ns;
    timeprecision 1ps;

    import npvl_pkg::*;

    localparam logic [MIRROR_W-1:0] MIRROR_NONE = '0;
    localparam coord_t COORD_MIN = coord_t'(24'h80_0000);
    localparam coord_t COORD_MAX = coord_t'(24'h7F_FFFF);
    localparam value_t VALUE_MIN = value_t'(32'h8000_0000);
    localparam value_t VALUE_MAX = value_t'(32'h7FFF_FFFF);
    localparam int     RANDOM_ITEMS = 580;
    localparam int     HOLD_CYCLES = 1500;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // quiet and hold_start are shared between the item sender and the result receiver.
    bit   quiet = 1'b0;
    bit   hold_start = 1'b0;
    int   cur_scan = 0;

    int   mismatch_count;
    int   faces_pending;

    npvl_req_if req_ch ();
    npvl_rsp_if rsp_ch ();
    npvl_cfg_if cfg_ch ();

    nearest_point_value_lookup dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    npvl_face_checker face_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .faces_pending  (faces_pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offer one item and wait for it to be taken. Valid stays high afterwards
    // so back-to-back items need only one assignment per edge.
    task automatic offer_item(input logic kind, input logic [INDEX_W-1:0] index,
                              input coord_t x, input coord_t y, input coord_t z,
                              input value_t value, input logic last);
        if (!quiet && $urandom_range(99) < 7) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.entry_index <= index;
        req_ch.point_x     <= x;
        req_ch.point_y     <= y;
        req_ch.point_z     <= z;
        req_ch.entry_value <= value;
        req_ch.last_vertex <= last;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Load items carry a random last_vertex bit, which the block ignores.
    task automatic send_load(input int index, input coord_t x, input coord_t y, input coord_t z,
                             input value_t value);
        offer_item(REQ_LOAD, INDEX_W'(index), x, y, z, value, 1'($urandom_range(0, 1)));
    endtask

    // Query items carry random index and value fields, which the block ignores.
    task automatic send_query(input coord_t x, input coord_t y, input coord_t z, input logic last);
        offer_item(REQ_QUERY, INDEX_W'($urandom()), x, y, z, value_t'($urandom()), last);
    endtask

    // Wait until every owed face result is in, then let a full scan and the
    // divider finish before the registers may change.
    task automatic drain_block();
        int eff;
        eff = (cur_scan > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : cur_scan;
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (faces_pending != 0);
        repeat (4 * eff + 80) @(posedge clk);
    endtask

    task automatic write_config(input logic [MIRROR_W-1:0] mirror, input int size);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_MIRROR_AXIS;
        cfg_ch.data  <= CFG_DATA_W'(mirror);
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= REG_TABLE_SIZE;
        cfg_ch.data  <= CFG_DATA_W'(size);
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_scan = size;
    endtask

    task automatic start_phase(input logic [MIRROR_W-1:0] mirror, input int size);
        drain_block();
        write_config(mirror, size);
    endtask

    // Clustered coordinates sit on a small grid so that ties are common.
    function automatic coord_t pick_coord(input bit clustered);
        if (clustered && $urandom_range(0, 3) != 0)
            return coord_t'(int'($urandom_range(0, 8)) - 4);
        case ($urandom_range(0, 9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return coord_t'(int'($urandom_range(0, 8)) - 4);
            default: return coord_t'($urandom());
        endcase
    endfunction

    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return value_t'(int'($urandom_range(0, 20)) - 10);
            default: return value_t'($urandom());
        endcase
    endfunction

    function automatic int pick_face_len(input bit short_faces);
        if (short_faces)
            return 1;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(9, 12);
        return $urandom_range(1, 5);
    endfunction

    // Result receiver: random stalls, one long hold-off, and none while quiet.
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_start && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= rst_n && (quiet || $urandom_range(99) >= 7);
            end
        end
    end

    // Item sender and verdict.
    initial
    begin
        int               random_items;
        int               phase;
        int               size;
        int               span;
        int               items_in_phase;
        int               face_left;
        bit               clustered;
        bit               short_faces;
        bit               last;
        logic [MIRROR_W-1:0] mirror;
        int               special_sizes[5];

        special_sizes = '{1024, 0, 2047, 1, 1025};

        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_LOAD;
        req_ch.entry_index <= '0;
        req_ch.point_x     <= '0;
        req_ch.point_y     <= '0;
        req_ch.point_z     <= '0;
        req_ch.entry_value <= '0;
        req_ch.last_vertex <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_MIRROR_AXIS;
        cfg_ch.data        <= '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty scan: vertices find nothing and a closed face reports zero.
        write_config(MIRROR_NONE, 0);
        send_query(COORD_MAX, COORD_MIN, coord_t'(0), 1'b0);
        send_query(coord_t'(5), coord_t'(-5), coord_t'(0), 1'b1);
        send_query(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);

        // Fill the whole table so that no scan reads an unwritten entry.
        for (int i = 0; i < TABLE_DEPTH_DEF; i++)
            send_load(i, pick_coord(1'b0), pick_coord(1'b0), pick_coord(1'b0), pick_value());

        // Four known entries: two points at equal distance from the origin
        // and the two corners of the coordinate range.
        start_phase(MIRROR_NONE, 4);
        send_load(0, coord_t'(-2), coord_t'(0), coord_t'(0), value_t'(10));
        send_load(1, coord_t'(2), coord_t'(0), coord_t'(0), value_t'(-7));
        send_load(2, COORD_MAX, COORD_MAX, COORD_MAX, VALUE_MIN);
        send_load(3, COORD_MIN, COORD_MIN, COORD_MIN, VALUE_MAX);
        send_query(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0);
        send_query(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        // A load outside the scanned range in the middle of an open face.
        send_load(1000, coord_t'(0), coord_t'(0), coord_t'(0), value_t'(99));
        send_query(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        // Negative sum whose average truncates toward zero.
        send_query(coord_t'(2), coord_t'(0), coord_t'(0), 1'b0);
        send_query(coord_t'(1), coord_t'(0), coord_t'(0), 1'b0);
        send_query(coord_t'(-2), coord_t'(0), coord_t'(0), 1'b1);

        // Mirror images: a tie between an entry and another's image, and the
        // image of the most negative coordinate.
        start_phase(MIRROR_X, 4);
        send_query(coord_t'(-2), coord_t'(0), coord_t'(0), 1'b0);
        send_query(COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
        start_phase(MIRROR_Y, 4);
        send_query(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);

        // Nine matching vertices in one face: the ninth is dropped but closes it.
        start_phase(MIRROR_Z, 4);
        send_query(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0);
        for (int i = 0; i < 8; i++)
            send_query(coord_t'(2), coord_t'(0), coord_t'(i), 1'(i == 7));

        // Random phases: faces of random length with random content, loads
        // mixed in, and a register setting of their own for each phase.
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            mirror = (phase < 4) ? MIRROR_W'(phase) : MIRROR_W'($urandom_range(0, 3));
            short_faces = (phase == 2);
            if (phase % 3 == 1 && phase / 3 < 5)
                size = special_sizes[phase / 3];
            else if (short_faces)
                size = 2;
            else
                size = $urandom_range(2, 24);
            clustered = 1'($urandom_range(0, 1));
            items_in_phase = (size > 64) ? 4 : $urandom_range(20, 50);
            span = (size > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : size;

            start_phase(mirror, size);
            quiet <= (phase == 5);
            // Receiver holds off while many short faces keep arriving.
            if (short_faces)
                hold_start <= 1'b1;

            face_left = pick_face_len(short_faces);
            repeat (items_in_phase) begin
                if (!short_faces && $urandom_range(0, 3) == 0) begin
                    if (span > 0 && $urandom_range(0, 9) < 7)
                        send_load($urandom_range(0, span - 1), pick_coord(clustered),
                                  pick_coord(clustered), pick_coord(clustered), pick_value());
                    else
                        send_load($urandom_range(0, TABLE_DEPTH_DEF - 1), pick_coord(clustered),
                                  pick_coord(clustered), pick_coord(clustered), pick_value());
                end else begin
                    face_left--;
                    last = (face_left == 0) || ($urandom_range(0, 19) == 0);
                    send_query(pick_coord(clustered), pick_coord(clustered),
                               pick_coord(clustered), last);
                    if (last)
                        face_left = pick_face_len(short_faces);
                end
                random_items++;
            end
            // Always send a closing vertex so the phase ends with no face left open.
            if (face_left != pick_face_len(short_faces) || 1'b1) begin
                send_query(pick_coord(clustered), pick_coord(clustered),
                           pick_coord(clustered), 1'b1);
                random_items++;
            end
            phase++;
        end

        drain_block();
        if (mismatch_count == 0 && faces_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #(4_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
